### rtl/sorted_priority_queue_macros.svh
// assertion macros for the sorted priority queue
// used by the top level; expects clk and rst in the including scope
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// condition that must hold at every edge out of reset
`define SPQ_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("sorted priority queue invariant violated");

// condition that must hold in the cycle after a trigger
`define SPQ_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("sorted priority queue update violated");

`endif

### rtl/spq_pkg.sv
// shared types and codes for the sorted priority queue
// no dependencies
`default_nettype none

package spq_pkg;

  localparam int VALUE_BITS    = 8;
  localparam int PRIORITY_BITS = 16;
  localparam int COUNT_BITS    = 7;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    op_t                              operation;
    logic [VALUE_BITS-1:0]            item_value;
    logic signed [PRIORITY_BITS-1:0]  item_priority;
  } req_t;

  typedef struct packed {
    status_t                          status;
    logic [VALUE_BITS-1:0]            out_value;
    logic signed [PRIORITY_BITS-1:0]  out_priority;
    logic                             head_valid;
    logic [VALUE_BITS-1:0]            head_value;
    logic signed [PRIORITY_BITS-1:0]  head_priority;
    logic [COUNT_BITS-1:0]            entry_count;
  } rsp_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0]            value;
    logic signed [PRIORITY_BITS-1:0]  prio;
  } entry_t;

  // broadcast to every cell in a cycle
  typedef struct packed {
    logic   shift_in;
    logic   shift_out;
    entry_t item;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/spq_cell.sv
// one slot of the sorted queue: holds an entry, compares it with the
// broadcast item and shifts toward the head or the tail; uses spq_pkg
`default_nettype none

module spq_cell (
  input  wire logic               clk,
  input  wire spq_pkg::cell_ctrl_t ctrl,
  input  wire logic               occupied,
  input  wire logic               prev_keep,
  input  wire spq_pkg::entry_t    prev_entry,
  input  wire spq_pkg::entry_t    next_entry,
  output spq_pkg::entry_t         entry,
  output spq_pkg::entry_t         entry_next,
  output logic                    keep
);

  // strictly higher priority stays ahead of the new item
  assign keep = occupied && ($signed(entry.prio) > $signed(ctrl.item.prio));

  always_comb begin
    entry_next = entry;
    if (ctrl.shift_in) begin
      if (!keep) begin
        // first slot not kept takes the item, the rest take their neighbor
        entry_next = prev_keep ? ctrl.item : prev_entry;
      end
    end else if (ctrl.shift_out) begin
      entry_next = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire

### rtl/spq_outbuf.sv
// result register with one skid stage between the queue and its consumer
// uses spq_pkg
`default_nettype none

module spq_outbuf (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire spq_pkg::rsp_t res,
  output logic               hold,
  output spq_pkg::rsp_t      rsp,
  output logic               rsp_valid,
  input  wire logic          rsp_stall
);

  logic          out_valid;
  logic          skid_valid;
  spq_pkg::rsp_t out_word;
  spq_pkg::rsp_t skid_word;
  logic          take;

  assign take = out_valid && !rsp_stall;
  assign hold = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load) begin
      // load only happens with the skid stage empty
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && (!out_valid || take)) begin
      out_word <= res;
    end else if (!load && take && skid_valid) begin
      out_word <= skid_word;
    end
    if (load && out_valid && !take) begin
      skid_word <= res;
    end
  end

  assign rsp       = out_word;
  assign rsp_valid = out_valid;

endmodule

`default_nettype wire

### rtl/sorted_priority_queue.sv
// Sorted priority queue of CAPACITY entries kept in a row of cells, head in
// cell 0. Every accepted word is an enqueue or a dequeue: all cells compare
// their priority with the broadcast item and shift at the same clock edge, so
// one operation is taken per cycle while req_stall is low. Its result word is
// registered in the output register or the skid stage. Equal priorities
// leave newest first. A result waiting on a stalled consumer is backed by one
// skid stage; req_stall rises only when both are full. No clearing pass is
// needed after reset: slot occupancy follows from the entry count.
// Depends on spq_pkg, spq_cell, spq_outbuf and the assertion macro header.
`default_nettype none

`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue #(
  parameter int CAPACITY = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire spq_pkg::req_t req,
  input  wire logic          req_valid,
  output logic               req_stall,
  output spq_pkg::rsp_t      rsp,
  output logic               rsp_valid,
  input  wire logic          rsp_stall
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic                full;
  logic                empty;
  logic                accept;
  logic                hold;
  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::entry_t     entries     [CAPACITY];
  spq_pkg::entry_t     entry_nexts [CAPACITY];
  logic [CAPACITY-1:0] keeps;
  spq_pkg::rsp_t       res;

  assign req_stall = hold;
  assign accept    = req_valid && !req_stall;
  assign full      = (count == CW'(CAPACITY));
  assign empty     = (count == '0);

  assign ctrl.shift_in      = accept && (req.operation == spq_pkg::OP_ENQUEUE) && !full;
  assign ctrl.shift_out     = accept && (req.operation == spq_pkg::OP_DEQUEUE) && !empty;
  assign ctrl.item.value    = req.item_value;
  assign ctrl.item.prio     = req.item_priority;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_pkg::entry_t prev_entry;
    spq_pkg::entry_t next_entry;
    logic            prev_keep;

    if (i == 0) begin : g_head
      assign prev_entry = ctrl.item;
      assign prev_keep  = 1'b1;
    end else begin : g_body
      assign prev_entry = entries[i-1];
      assign prev_keep  = keeps[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_entry = entries[i];
    end else begin : g_inner
      assign next_entry = entries[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (CW'(i) < count),
      .prev_keep  (prev_keep),
      .prev_entry (prev_entry),
      .next_entry (next_entry),
      .entry      (entries[i]),
      .entry_next (entry_nexts[i]),
      .keep       (keeps[i])
    );
  end

  always_comb begin
    count_next = count;
    if (ctrl.shift_in) begin
      count_next = count + CW'(1);
    end else if (ctrl.shift_out) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_comb begin
    res = '0;
    res.status = spq_pkg::ST_OK;
    if (req.operation == spq_pkg::OP_ENQUEUE) begin
      if (full) begin
        res.status = spq_pkg::ST_OVERFLOW;
      end
    end else if (empty) begin
      res.status = spq_pkg::ST_UNDERFLOW;
    end
    if (ctrl.shift_out) begin
      res.out_value    = entries[0].value;
      res.out_priority = entries[0].prio;
    end
    if (count_next != '0) begin
      res.head_valid    = 1'b1;
      res.head_value    = entry_nexts[0].value;
      res.head_priority = entry_nexts[0].prio;
    end
    res.entry_count = spq_pkg::COUNT_BITS'(count_next);
  end

  spq_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .res       (res),
    .hold      (hold),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
  );

  `SPQ_ASSERT_ALWAYS(a_count_bound, count <= CW'(CAPACITY))
  `SPQ_ASSERT_NEXT(a_enq_grows, ctrl.shift_in, count == $past(count) + CW'(1))
  `SPQ_ASSERT_NEXT(a_deq_shrinks, ctrl.shift_out, count == $past(count) - CW'(1))
  `SPQ_ASSERT_NEXT(a_idle_count, !accept, $stable(count))
  `SPQ_ASSERT_NEXT(a_accept_shows, accept, rsp_valid)

endmodule

`default_nettype wire
